@@ sv/srd_pkg.sv @@
// Shared constants for the stick radial deadzone block.
package srd_pkg;

  localparam int RAW_W         = 8;
  localparam int DZ_W          = 14;
  localparam int OUT_W         = 16;
  localparam int FRAC_BITS_DEF = 14;

  localparam logic [RAW_W-1:0] RAW_CENTER = 8'd128;
  localparam logic [DZ_W-1:0]  DZ_RESET   = 14'd2458;

endpackage

@@ sv/stick_radial_deadzone.sv @@
// Stick radial deadzone conditioner: pipelined square root and two dividers per axis.
//
// Input channel: in_valid_i with raw_x_i and raw_y_i; a request is taken when
// in_valid_i is high and in_stall_o is low. Output channel: out_valid_o with
// out_x_o, out_y_o and in_deadzone_o; a request is delivered when out_valid_o is
// high and out_stall_i is low. Outputs are signed values with FRAC_BITS fraction
// bits, clamped to +-1.0 and inside the deadzone forced to zero.
// The deadzone radius is written on the cfg channel (cfg_ready_o is always high)
// and sampled per request at entry.
// Throughput is one sample per cycle unless the receiver stalls. The pipeline has
// multiply and compare stages, one square root stage per result bit,
// one restoring divider step per quotient bit for the radial scale and for the
// normalization by (1 - deadzone), and an output register.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall_o goes high; nothing is dropped or repeated.
// Reset clears all valid bits and restores the radius to about 0.15.
module stick_radial_deadzone import srd_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [DZ_W-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [RAW_W-1:0]        raw_x_i,
  input  logic [RAW_W-1:0]        raw_y_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] out_x_o,
  output logic signed [OUT_W-1:0] out_y_o,
  output logic                    in_deadzone_o
);

  localparam int SXW = FRAC_BITS + 1;
  localparam int MW  = SXW;
  localparam int S2W = 2 * SXW;
  localparam int PW  = SXW + MW;
  localparam int DW2 = FRAC_BITS + 1;
  localparam int QW2 = FRAC_BITS;
  localparam int CW  = (MW > DZ_W) ? MW : DZ_W;
  localparam int LW  = (S2W > 2 * DZ_W) ? S2W : 2 * DZ_W;
  localparam int OW  = (FRAC_BITS + 2 > OUT_W) ? FRAC_BITS + 2 : OUT_W;
  localparam int UP  = FRAC_BITS - 7;
  localparam int NSQ = MW;
  localparam int ND1 = SXW;
  localparam int ND2 = QW2;
  localparam int NST = NSQ + ND1 + ND2 + 5;

  localparam logic [CW-1:0]  ONE_C = CW'(1) << FRAC_BITS;
  localparam logic [DW2-1:0] ONE_D = DW2'(1) << FRAC_BITS;

  typedef struct packed {
    logic [SXW-1:0]  sx;
    logic [SXW-1:0]  sy;
    logic            nx;
    logic            ny;
    logic [DZ_W-1:0] dz;
    logic [S2W-1:0]  sqx;
    logic [S2W-1:0]  sqy;
  } sa_t;

  typedef struct packed {
    logic [SXW-1:0]  sx;
    logic [SXW-1:0]  sy;
    logic            nx;
    logic            ny;
    logic [DZ_W-1:0] dz;
    logic            dzin;
    logic [S2W-1:0]  s2;
    logic [MW:0]     rem;
    logic [MW-1:0]   root;
  } sq_t;

  typedef struct packed {
    logic           nx;
    logic           ny;
    logic           zero;
    logic           dzin;
    logic [DW2-1:0] den;
    logic [MW-1:0]  mag;
    logic [PW-1:0]  numx;
    logic [PW-1:0]  numy;
    logic [MW-1:0]  remx;
    logic [MW-1:0]  remy;
    logic [SXW-1:0] qx;
    logic [SXW-1:0] qy;
  } d1_t;

  typedef struct packed {
    logic           nx;
    logic           ny;
    logic           zero;
    logic           dzin;
    logic [DW2-1:0] den;
    logic           satx;
    logic           saty;
    logic [DW2-1:0] remx;
    logic [DW2-1:0] remy;
    logic [QW2-1:0] qx;
    logic [QW2-1:0] qy;
  } d2_t;

  logic [DZ_W-1:0] dz_q;
  logic [NST-1:0]  vld_q;
  logic            en;

  sa_t sa_d, sa_q;
  sq_t sq_d [NSQ+1];
  sq_t sq_q [NSQ+1];
  d1_t d1_d [ND1+1];
  d1_t d1_q [ND1+1];
  d2_t d2_d [ND2+1];
  d2_t d2_q [ND2+1];

  logic signed [OUT_W-1:0] out_x_d, out_x_q, out_y_d, out_y_q;
  logic                    dzf_d, dzf_q;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = vld_q[NST-1];
  assign in_stall_o  = out_valid_o & out_stall_i;
  assign en          = ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= DZ_RESET;
    end else if (cfg_valid_i) begin
      dz_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // center removal and squares
  always_comb begin
    logic [RAW_W-1:0] ax, ay;
    sa_d.nx = raw_x_i < RAW_CENTER;
    sa_d.ny = raw_y_i < RAW_CENTER;
    ax = sa_d.nx ? RAW_CENTER - raw_x_i : raw_x_i - RAW_CENTER;
    ay = sa_d.ny ? RAW_CENTER - raw_y_i : raw_y_i - RAW_CENTER;
    sa_d.sx  = SXW'(ax) << UP;
    sa_d.sy  = SXW'(ay) << UP;
    sa_d.dz  = dz_q;
    sa_d.sqx = S2W'(sa_d.sx) * S2W'(sa_d.sx);
    sa_d.sqy = S2W'(sa_d.sy) * S2W'(sa_d.sy);
  end

  // magnitude sum, deadzone test, square root digit recurrence
  always_comb begin
    logic [S2W-1:0]  s2;
    logic [MW+2:0]   r, t;
    s2 = sa_q.sqx + sa_q.sqy;
    sq_d[0].sx   = sa_q.sx;
    sq_d[0].sy   = sa_q.sy;
    sq_d[0].nx   = sa_q.nx;
    sq_d[0].ny   = sa_q.ny;
    sq_d[0].dz   = sa_q.dz;
    sq_d[0].s2   = s2;
    sq_d[0].dzin = (CW'(sa_q.dz) >= ONE_C) ||
                   (LW'(s2) < LW'(LW'(sa_q.dz) * LW'(sa_q.dz)));
    sq_d[0].rem  = '0;
    sq_d[0].root = '0;
    for (int k = 0; k < NSQ; k++) begin
      sq_d[k+1] = sq_q[k];
      r = {sq_q[k].rem, sq_q[k].s2[S2W-1-2*k -: 2]};
      t = (MW+3)'({sq_q[k].root, 2'b01});
      if (r >= t) begin
        sq_d[k+1].rem  = (MW+1)'(r - t);
        sq_d[k+1].root = {sq_q[k].root[MW-2:0], 1'b1};
      end else begin
        sq_d[k+1].rem  = r[MW:0];
        sq_d[k+1].root = {sq_q[k].root[MW-2:0], 1'b0};
      end
    end
  end

  // radial scale a*(mag-dz)/mag
  always_comb begin
    logic [MW-1:0] diff;
    logic [MW:0]   tx, ty;
    diff = MW'(CW'(sq_q[NSQ].root) - CW'(sq_q[NSQ].dz));
    d1_d[0].nx   = sq_q[NSQ].nx;
    d1_d[0].ny   = sq_q[NSQ].ny;
    d1_d[0].zero = sq_q[NSQ].s2 == '0;
    d1_d[0].dzin = sq_q[NSQ].dzin;
    d1_d[0].den  = DW2'(ONE_C - CW'(sq_q[NSQ].dz));
    d1_d[0].mag  = sq_q[NSQ].root;
    d1_d[0].numx = PW'(sq_q[NSQ].sx) * PW'(diff);
    d1_d[0].numy = PW'(sq_q[NSQ].sy) * PW'(diff);
    d1_d[0].remx = '0;
    d1_d[0].remy = '0;
    d1_d[0].qx   = '0;
    d1_d[0].qy   = '0;
    for (int k = 0; k < ND1; k++) begin
      d1_d[k+1] = d1_q[k];
      if (k == 0) begin
        tx = {d1_q[k].numx[PW-1 -: MW], d1_q[k].numx[SXW-1]};
        ty = {d1_q[k].numy[PW-1 -: MW], d1_q[k].numy[SXW-1]};
      end else begin
        tx = {d1_q[k].remx, d1_q[k].numx[SXW-1-k]};
        ty = {d1_q[k].remy, d1_q[k].numy[SXW-1-k]};
      end
      if (tx >= {1'b0, d1_q[k].mag}) begin
        d1_d[k+1].remx = MW'(tx - {1'b0, d1_q[k].mag});
        d1_d[k+1].qx   = {d1_q[k].qx[SXW-2:0], 1'b1};
      end else begin
        d1_d[k+1].remx = tx[MW-1:0];
        d1_d[k+1].qx   = {d1_q[k].qx[SXW-2:0], 1'b0};
      end
      if (ty >= {1'b0, d1_q[k].mag}) begin
        d1_d[k+1].remy = MW'(ty - {1'b0, d1_q[k].mag});
        d1_d[k+1].qy   = {d1_q[k].qy[SXW-2:0], 1'b1};
      end else begin
        d1_d[k+1].remy = ty[MW-1:0];
        d1_d[k+1].qy   = {d1_q[k].qy[SXW-2:0], 1'b0};
      end
    end
  end

  // normalize by (one-dz); q >= one-dz means the result clamps to one
  always_comb begin
    logic [DW2:0] tx, ty;
    d2_d[0].nx   = d1_q[ND1].nx;
    d2_d[0].ny   = d1_q[ND1].ny;
    d2_d[0].zero = d1_q[ND1].zero;
    d2_d[0].dzin = d1_q[ND1].dzin;
    d2_d[0].den  = d1_q[ND1].den;
    d2_d[0].satx = DW2'(d1_q[ND1].qx) >= d1_q[ND1].den;
    d2_d[0].saty = DW2'(d1_q[ND1].qy) >= d1_q[ND1].den;
    d2_d[0].remx = DW2'(d1_q[ND1].qx);
    d2_d[0].remy = DW2'(d1_q[ND1].qy);
    d2_d[0].qx   = '0;
    d2_d[0].qy   = '0;
    for (int k = 0; k < ND2; k++) begin
      d2_d[k+1] = d2_q[k];
      tx = {d2_q[k].remx, 1'b0};
      ty = {d2_q[k].remy, 1'b0};
      if (tx >= {1'b0, d2_q[k].den}) begin
        d2_d[k+1].remx = DW2'(tx - {1'b0, d2_q[k].den});
        d2_d[k+1].qx   = {d2_q[k].qx[QW2-2:0], 1'b1};
      end else begin
        d2_d[k+1].remx = tx[DW2-1:0];
        d2_d[k+1].qx   = {d2_q[k].qx[QW2-2:0], 1'b0};
      end
      if (ty >= {1'b0, d2_q[k].den}) begin
        d2_d[k+1].remy = DW2'(ty - {1'b0, d2_q[k].den});
        d2_d[k+1].qy   = {d2_q[k].qy[QW2-2:0], 1'b1};
      end else begin
        d2_d[k+1].remy = ty[DW2-1:0];
        d2_d[k+1].qy   = {d2_q[k].qy[QW2-2:0], 1'b0};
      end
    end
  end

  // clamp, sign, force zero
  always_comb begin
    logic [DW2-1:0] vx, vy;
    logic [OW-1:0]  rx, ry;
    vx = d2_q[ND2].satx ? ONE_D : DW2'(d2_q[ND2].qx);
    vy = d2_q[ND2].saty ? ONE_D : DW2'(d2_q[ND2].qy);
    rx = d2_q[ND2].nx ? OW'(0) - OW'(vx) : OW'(vx);
    ry = d2_q[ND2].ny ? OW'(0) - OW'(vy) : OW'(vy);
    dzf_d = d2_q[ND2].dzin;
    if (d2_q[ND2].dzin || d2_q[ND2].zero) begin
      out_x_d = '0;
      out_y_d = '0;
    end else begin
      out_x_d = rx[OUT_W-1:0];
      out_y_d = ry[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q <= sa_d;
      for (int k = 0; k <= NSQ; k++) sq_q[k] <= sq_d[k];
      for (int k = 0; k <= ND1; k++) d1_q[k] <= d1_d[k];
      for (int k = 0; k <= ND2; k++) d2_q[k] <= d2_d[k];
      out_x_q <= out_x_d;
      out_y_q <= out_y_d;
      dzf_q   <= dzf_d;
    end
  end

  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign in_deadzone_o = dzf_q;

endmodule
